[design/pitch_yaw_direction_tracker_assert.svh]
// Assertion macros for the pitch/yaw direction tracker RTL
`ifndef PITCH_YAW_DIRECTION_TRACKER_ASSERT_SVH
`define PITCH_YAW_DIRECTION_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define PYD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PYD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PYD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PYD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[design/pyd_pkg.sv]
// Shared widths, constants and helper functions of the direction tracker
package pyd_pkg;

    localparam int STEP_W           = 14;
    localparam int PITCH_W          = 14;
    localparam int YAW_W            = 15;
    localparam int DEG_W            = 15;   // angle magnitude into the converter
    localparam int OUT_W            = 16;
    localparam int ANGLE_W          = 32;   // binary angle, full turn = 2^32
    localparam int VEC_W            = 32;   // Q2.30 rotator vector
    localparam int PROD_W           = 2 * VEC_W;
    localparam int PROD_LSB         = 45;
    localparam int RND_W            = PROD_W - PROD_LSB;
    localparam int DIRY_LSB         = 15;
    localparam int PITCH_LIMIT      = 5696;
    localparam int YAW_TURN         = 23040;
    localparam int Q14_ONE          = 16384;
    localparam int CORDIC_GAIN      = 652032874;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W       = 5;

    localparam logic [ANGLE_W-1:0] TURN_QUARTER       = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] TURN_THREE_QUARTER = 32'hC000_0000;

    // arctan(2^-i) as a binary angle
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        case (idx)
            5'd0:    return 32'h2000_0000;
            5'd1:    return 32'h12E4_051E;
            5'd2:    return 32'h09FB_385B;
            5'd3:    return 32'h0511_11D4;
            5'd4:    return 32'h028B_0D43;
            5'd5:    return 32'h0145_D7E1;
            5'd6:    return 32'h00A2_F61E;
            5'd7:    return 32'h0051_7C55;
            5'd8:    return 32'h0028_BE53;
            5'd9:    return 32'h0014_5F2F;
            5'd10:   return 32'h000A_2F98;
            5'd11:   return 32'h0005_17CC;
            5'd12:   return 32'h0002_8BE6;
            5'd13:   return 32'h0001_45F3;
            5'd14:   return 32'h0000_A2FA;
            5'd15:   return 32'h0000_517D;
            5'd16:   return 32'h0000_28BE;
            5'd17:   return 32'h0000_145F;
            5'd18:   return 32'h0000_0A30;
            5'd19:   return 32'h0000_0518;
            5'd20:   return 32'h0000_028C;
            5'd21:   return 32'h0000_0146;
            5'd22:   return 32'h0000_00A3;
            5'd23:   return 32'h0000_0051;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // round half up by one bit and saturate to +-1.0 in Q1.14
    function automatic logic signed [OUT_W-1:0] round_q14(input logic signed [RND_W-1:0] v);
        logic signed [RND_W:0] t;
        t = (RND_W+1)'(v) + (RND_W+1)'(1);
        t = t >>> 1;
        if (t > Q14_ONE) begin
            return OUT_W'(Q14_ONE);
        end
        if (t < -Q14_ONE) begin
            return OUT_W'(-Q14_ONE);
        end
        return OUT_W'(t);
    endfunction

endpackage

[design/pyd_angle_div.sv]
// Bit-serial conversion of an angle magnitude in 1/64 degree to a binary angle
`include "pitch_yaw_direction_tracker_assert.svh"

module pyd_angle_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [pyd_pkg::DEG_W-1:0]     mag,
    output logic [pyd_pkg::ANGLE_W-1:0]   turns,
    output logic                          done
);
    import pyd_pkg::*;

    localparam int CNT_W = $clog2(ANGLE_W);

    logic [DEG_W-1:0]   rem_reg, rem_next;
    logic [ANGLE_W-1:0] num_reg, num_next;
    logic [ANGLE_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DEG_W:0]     trial;
    logic               fits;

    // long division of mag * 2^32 + YAW_TURN/2 by YAW_TURN, one quotient bit a cycle
    always_comb begin
        trial     = {rem_reg, num_reg[ANGLE_W-1]};
        fits      = trial >= (DEG_W+1)'(YAW_TURN);
        rem_next  = rem_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = mag;
            num_next  = ANGLE_W'(YAW_TURN / 2);
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEG_W'(trial - (DEG_W+1)'(YAW_TURN)) : trial[DEG_W-1:0];
            num_next = num_reg << 1;
            quo_next = {quo_reg[ANGLE_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ANGLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        quo_reg <= quo_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign turns = quo_reg;
    assign done  = done_reg;

    `PYD_ASSERT_IMP(a_rem_below_turn, aclk, aresetn, busy_reg, rem_reg < DEG_W'(YAW_TURN), "partial remainder reached the divisor")
    `PYD_ASSERT_IMP(a_done_after_busy, aclk, aresetn, done_reg, $past(busy_reg), "divider done without a running division")

endmodule

[design/pyd_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle
module pyd_cordic #(
    parameter int unsigned STEPS = pyd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [pyd_pkg::ANGLE_W-1:0]  angle,
    output logic signed [pyd_pkg::VEC_W-1:0]    cos_out,
    output logic signed [pyd_pkg::VEC_W-1:0]    sin_out,
    output logic                                done
);
    import pyd_pkg::*;

    localparam int IDX_W = $clog2(STEPS);

    logic signed [VEC_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [VEC_W-1:0]   dx, dy;
    logic signed [ANGLE_W-1:0] z_reg, z_next, step_ang;
    logic [IDX_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb begin
        dx        = y_reg >>> cnt_reg;
        dy        = x_reg >>> cnt_reg;
        step_ang  = signed'(atan_turn(ATAN_IDX_W'(cnt_reg)));
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = VEC_W'(CORDIC_GAIN);
            y_next    = '0;
            z_next    = angle;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // rotate toward zero residual angle
            if (!z_reg[ANGLE_W-1]) begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_ang;
            end else begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_ang;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == IDX_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign cos_out = x_reg;
    assign sin_out = y_reg;
    assign done    = done_reg;

endmodule

[design/pyd_serial_mul.sv]
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle
module pyd_serial_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [pyd_pkg::VEC_W-1:0]   mcand,
    input  logic signed [pyd_pkg::VEC_W-1:0]   mplier,
    output logic signed [pyd_pkg::PROD_W-1:0]  prod,
    output logic                               done
);
    import pyd_pkg::*;

    localparam int CNT_W = $clog2(VEC_W);

    logic signed [VEC_W:0]   hi_reg, hi_next;
    logic [VEC_W-1:0]        lo_reg, lo_next;
    logic [VEC_W-1:0]        mplier_reg, mplier_next;
    logic signed [VEC_W-1:0] mcand_reg, mcand_next;
    logic signed [VEC_W-1:0] addend;
    logic signed [VEC_W+1:0] sum;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    always_comb begin
        addend = mplier_reg[0] ? mcand_reg : '0;
        // the top multiplier bit carries negative weight
        if (cnt_reg == CNT_W'(VEC_W - 1)) begin
            sum = (VEC_W+2)'(hi_reg) - (VEC_W+2)'(addend);
        end else begin
            sum = (VEC_W+2)'(hi_reg) + (VEC_W+2)'(addend);
        end
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            hi_next     = '0;
            lo_next     = '0;
            mplier_next = mplier;
            mcand_next  = mcand;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            hi_next     = sum[VEC_W+1:1];
            lo_next     = {sum[0], lo_reg[VEC_W-1:1]};
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VEC_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign prod = {hi_reg[VEC_W-1:0], lo_reg};
    assign done = done_reg;

endmodule

[design/pitch_yaw_direction_tracker.sv]
// Top level: pitch/yaw accumulator returning the Q1.14 unit direction vector
//
//  Port group | Handshake         | Payload
//  -----------+-------------------+-------------------------------------------------
//  input      | s_valid / s_ready | s_pitch_step, s_yaw_step (14b signed, 1/64 deg)
//  result     | m_valid / m_ready | m_dir_x, m_dir_y, m_dir_z (16b Q1.14), m_pitch_clamped
//
// An item passes through bit-serial angle conversion, the CORDIC rotations, bit-serial
// multiplies and a sequencing state before its result is registered; a new input is
// taken only once the state machine is back in idle.
// Synchronous reset zeroes pitch and yaw and empties the result register.
// A held-off m_ready keeps the result; a following item waits finished in the multipliers.
`include "pitch_yaw_direction_tracker_assert.svh"

module pitch_yaw_direction_tracker #(
    parameter int unsigned CORDIC_STEPS = pyd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [pyd_pkg::STEP_W-1:0]  s_pitch_step,
    input  logic signed [pyd_pkg::STEP_W-1:0]  s_yaw_step,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pyd_pkg::OUT_W-1:0]   m_dir_x,
    output logic signed [pyd_pkg::OUT_W-1:0]   m_dir_y,
    output logic signed [pyd_pkg::OUT_W-1:0]   m_dir_z,
    output logic                               m_pitch_clamped
);
    import pyd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic signed [PITCH_W-1:0] pitch_angle_reg, pitch_angle_next;
    logic [YAW_W-1:0]          yaw_angle_reg, yaw_angle_next;
    logic                      clamp_reg, clamp_next;
    logic                      pitch_neg_reg, pitch_neg_next;
    logic                      fold_reg, fold_next;
    logic                      m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]   dir_x_reg, dir_x_next;
    logic signed [OUT_W-1:0]   dir_y_reg, dir_y_next;
    logic signed [OUT_W-1:0]   dir_z_reg, dir_z_next;
    logic                      pclamp_reg, pclamp_next;

    logic signed [PITCH_W:0]   pitch_sum;
    logic signed [PITCH_W-1:0] pitch_new;
    logic                      pitch_hit;
    logic [DEG_W-1:0]          pitch_mag;
    logic signed [YAW_W:0]     yaw_sum;
    logic [YAW_W-1:0]          yaw_new;
    logic                      accept;

    logic [ANGLE_W-1:0]        p_turns_raw, y_turns;
    logic signed [ANGLE_W-1:0] p_angle, y_angle;
    logic                      y_fold;
    logic                      p_div_done, y_div_done, div_done;
    logic signed [VEC_W-1:0]   p_cos, p_sin, y_cos, y_sin, y_cos_adj, y_sin_adj;
    logic                      p_rot_done, y_rot_done, rot_done;
    logic signed [PROD_W-1:0]  x_prod, z_prod;
    logic                      x_mul_done, z_mul_done, mul_done;

    assign accept = s_valid && s_ready;

    // angle update: clamp pitch, wrap yaw into one turn
    always_comb begin
        pitch_sum = (PITCH_W+1)'(pitch_angle_reg) + (PITCH_W+1)'(s_pitch_step);
        pitch_hit = 1'b1;
        if (pitch_sum > PITCH_LIMIT) begin
            pitch_new = PITCH_W'(PITCH_LIMIT);
        end else if (pitch_sum < -PITCH_LIMIT) begin
            pitch_new = PITCH_W'(-PITCH_LIMIT);
        end else begin
            pitch_new = pitch_sum[PITCH_W-1:0];
            pitch_hit = 1'b0;
        end
        pitch_mag = pitch_new[PITCH_W-1] ? DEG_W'(-pitch_new) : DEG_W'(pitch_new);

        yaw_sum = signed'({1'b0, yaw_angle_reg}) + (YAW_W+1)'(s_yaw_step);
        if (yaw_sum < 0) begin
            yaw_new = YAW_W'(yaw_sum + (YAW_W+1)'(YAW_TURN));
        end else if (yaw_sum >= YAW_TURN) begin
            yaw_new = YAW_W'(yaw_sum - (YAW_W+1)'(YAW_TURN));
        end else begin
            yaw_new = yaw_sum[YAW_W-1:0];
        end
    end

    pyd_angle_div u_pitch_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (pitch_mag),
        .turns   (p_turns_raw),
        .done    (p_div_done)
    );

    pyd_angle_div u_yaw_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .mag     (DEG_W'(yaw_new)),
        .turns   (y_turns),
        .done    (y_div_done)
    );

    assign div_done = p_div_done && y_div_done;

    // fold yaw from the back half-turn into +-90 degrees; negate its results later
    assign y_fold  = (y_turns > TURN_QUARTER) && (y_turns < TURN_THREE_QUARTER);
    assign y_angle = y_fold ? signed'({~y_turns[ANGLE_W-1], y_turns[ANGLE_W-2:0]})
                            : signed'(y_turns);
    assign p_angle = pitch_neg_reg ? signed'(ANGLE_W'(0) - p_turns_raw) : signed'(p_turns_raw);

    pyd_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_pitch_rot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_done),
        .angle   (p_angle),
        .cos_out (p_cos),
        .sin_out (p_sin),
        .done    (p_rot_done)
    );

    pyd_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_yaw_rot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_done),
        .angle   (y_angle),
        .cos_out (y_cos),
        .sin_out (y_sin),
        .done    (y_rot_done)
    );

    assign rot_done  = p_rot_done && y_rot_done;
    assign y_cos_adj = fold_reg ? -y_cos : y_cos;
    assign y_sin_adj = fold_reg ? -y_sin : y_sin;

    pyd_serial_mul u_x_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rot_done),
        .mcand   (p_cos),
        .mplier  (y_sin_adj),
        .prod    (x_prod),
        .done    (x_mul_done)
    );

    pyd_serial_mul u_z_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (rot_done),
        .mcand   (p_cos),
        .mplier  (y_cos_adj),
        .prod    (z_prod),
        .done    (z_mul_done)
    );

    assign mul_done = x_mul_done && z_mul_done;

    always_comb begin
        state_next       = state_reg;
        pitch_angle_next = pitch_angle_reg;
        yaw_angle_next   = yaw_angle_reg;
        clamp_next       = clamp_reg;
        pitch_neg_next   = pitch_neg_reg;
        fold_next        = fold_reg;
        m_valid_next     = m_valid_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        dir_z_next       = dir_z_reg;
        pclamp_next      = pclamp_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    pitch_angle_next = pitch_new;
                    yaw_angle_next   = yaw_new;
                    clamp_next       = pitch_hit;
                    pitch_neg_next   = pitch_new[PITCH_W-1];
                    state_next       = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    fold_next  = y_fold;
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                if (rot_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mul_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    dir_x_next   = round_q14(RND_W'(x_prod >>> PROD_LSB));
                    dir_y_next   = round_q14(RND_W'(p_sin >>> DIRY_LSB));
                    dir_z_next   = round_q14(RND_W'(z_prod >>> PROD_LSB));
                    pclamp_next  = clamp_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        clamp_reg     <= clamp_next;
        pitch_neg_reg <= pitch_neg_next;
        fold_reg      <= fold_next;
        dir_x_reg     <= dir_x_next;
        dir_y_reg     <= dir_y_next;
        dir_z_reg     <= dir_z_next;
        pclamp_reg    <= pclamp_next;
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pitch_angle_reg <= '0;
            yaw_angle_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            pitch_angle_reg <= pitch_angle_next;
            yaw_angle_reg   <= yaw_angle_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_dir_x         = dir_x_reg;
    assign m_dir_y         = dir_y_reg;
    assign m_dir_z         = dir_z_reg;
    assign m_pitch_clamped = pclamp_reg;

    `PYD_ASSERT_IMP(a_pitch_in_limit, aclk, aresetn, 1'b1, (pitch_angle_reg <= PITCH_LIMIT) && (pitch_angle_reg >= -PITCH_LIMIT), "stored pitch outside the limit")
    `PYD_ASSERT_IMP(a_yaw_in_turn, aclk, aresetn, 1'b1, yaw_angle_reg < YAW_TURN, "stored yaw outside one turn")
    `PYD_ASSERT_IMP(a_units_in_step, aclk, aresetn, 1'b1, (p_div_done == y_div_done) && (p_rot_done == y_rot_done) && (x_mul_done == z_mul_done), "paired serial units out of step")
    `PYD_ASSERT_IMP(a_mul_done_in_stage, aclk, aresetn, mul_done, state_reg == ST_MUL, "multiply finished outside its stage")
    `PYD_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while an item is in flight")

endmodule

[sim/pitch_yaw_direction_tracker_tb.sv]
// Self-checking testbench for the pitch/yaw direction tracker with its own CORDIC predictor
module pitch_yaw_direction_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pyd_pkg::STEP_W;
    import pyd_pkg::OUT_W;
    import pyd_pkg::PITCH_LIMIT;
    import pyd_pkg::YAW_TURN;
    import pyd_pkg::Q14_ONE;

    localparam int ROT_STEPS   = pyd_pkg::CORDIC_STEPS_DEF;
    localparam int ATAN_DEPTH  = 24;
    localparam int QUARTER     = YAW_TURN / 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 120;

    localparam longint unsigned ROT_GAIN = 64'd652032874;

    localparam bit [31:0] ATAN_TURNS [ATAN_DEPTH] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };

    typedef struct {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    clamped;
    } view_t;

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic signed [STEP_W-1:0] s_pitch_step    = '0;
    logic signed [STEP_W-1:0] s_yaw_step      = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic signed [OUT_W-1:0]  m_dir_x;
    logic signed [OUT_W-1:0]  m_dir_y;
    logic signed [OUT_W-1:0]  m_dir_z;
    logic                     m_pitch_clamped;

    view_t view_q[$];
    int    pitch_units;
    int    yaw_units;
    int    items_sent;
    int    views_checked;
    int    clamp_count;
    int    wrap_count;
    int    error_count;
    int    cycle_count;
    bit    quiet_tail;

    pitch_yaw_direction_tracker #(
        .CORDIC_STEPS(ROT_STEPS)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pitch_step   (s_pitch_step),
        .s_yaw_step     (s_yaw_step),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dir_x        (m_dir_x),
        .m_dir_y        (m_dir_y),
        .m_dir_z        (m_dir_z),
        .m_pitch_clamped(m_pitch_clamped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, view_q.size());
        $display("pitch_yaw_direction_tracker_tb: done, errors");
        $finish;
    end

    // magnitude in 1/64 degree to a 32-bit binary angle, rounded half up, sign applied after
    function automatic bit [31:0] angle_to_turns(input int a);
        longint unsigned mag;
        bit [31:0]       t;
        mag = (a < 0) ? longint'(-a) : longint'(a);
        t = 32'(((mag << 32) + (YAW_TURN / 2)) / YAW_TURN);
        return (a < 0) ? (32'd0 - t) : t;
    endfunction

    // cos and sin in Q2.30 of a binary angle within +-90 degrees
    function automatic void rotate_unit(input bit [31:0] turns, output longint c,
                                        output longint s);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = longint'(ROT_GAIN);
        y = 0;
        z = longint'(int'(turns));
        for (int i = 0; i < ROT_STEPS && i < ATAN_DEPTH; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TURNS[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TURNS[i]);
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic logic signed [OUT_W-1:0] q14_round(input longint v, input int shift);
        longint t;
        t = (v + (longint'(1) <<< (shift - 1))) >>> shift;
        if (t > Q14_ONE) begin
            t = Q14_ONE;
        end
        if (t < -Q14_ONE) begin
            t = -Q14_ONE;
        end
        return OUT_W'(t);
    endfunction

    task automatic advance_view(input logic signed [STEP_W-1:0] dp,
                                input logic signed [STEP_W-1:0] dy, output view_t v);
        int        p;
        int        yv;
        bit [31:0] yt;
        longint    cp;
        longint    sp;
        longint    cy;
        longint    sy;
        p = pitch_units + int'(dp);
        v.clamped = 1'b0;
        if (p > PITCH_LIMIT) begin
            p = PITCH_LIMIT;
            v.clamped = 1'b1;
        end
        if (p < -PITCH_LIMIT) begin
            p = -PITCH_LIMIT;
            v.clamped = 1'b1;
        end
        yv = yaw_units + int'(dy);
        if (yv < 0 || yv >= YAW_TURN) begin
            wrap_count++;
        end
        yv = yv % YAW_TURN;
        if (yv < 0) begin
            yv = yv + YAW_TURN;
        end
        pitch_units = p;
        yaw_units = yv;
        if (v.clamped) begin
            clamp_count++;
        end

        rotate_unit(angle_to_turns(p), cp, sp);
        yt = angle_to_turns(yv);
        // fold the back half-turn of yaw onto the front and flip both results
        if (yt > 32'h4000_0000 && yt < 32'hC000_0000) begin
            rotate_unit(yt - 32'h8000_0000, cy, sy);
            cy = -cy;
            sy = -sy;
        end else begin
            rotate_unit(yt, cy, sy);
        end
        v.x = q14_round(cp * sy, 46);
        v.y = q14_round(sp, 16);
        v.z = q14_round(cp * cy, 46);
    endtask

    // one transfer on the input side; caller is at a rising edge
    task automatic send_step(input logic signed [STEP_W-1:0] dp,
                             input logic signed [STEP_W-1:0] dy);
        view_t v;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pitch_step <= dp;
        s_yaw_step   <= dy;
        do @(posedge aclk); while (!s_ready);
        advance_view(dp, dy, v);
        view_q.push_back(v);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (view_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        view_t e;
        if (aresetn && m_valid && m_ready) begin
            if (view_q.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected: x %0d y %0d z %0d clamped %0b",
                         $time, m_dir_x, m_dir_y, m_dir_z, m_pitch_clamped);
            end else begin
                e = view_q.pop_front();
                views_checked++;
                if (m_dir_x !== e.x || m_dir_y !== e.y || m_dir_z !== e.z
                        || m_pitch_clamped !== e.clamped) begin
                    error_count++;
                    $display("%0t: result %0d expected x %0d y %0d z %0d clamped %0b",
                             $time, views_checked, e.x, e.y, e.z, e.clamped);
                    $display("%0t: result %0d actual   x %0d y %0d z %0d clamped %0b",
                             $time, views_checked, m_dir_x, m_dir_y, m_dir_z,
                             m_pitch_clamped);
                end
            end
        end
    end

    // receiver: ready bursts broken by stalls, steady ready in the tail
    initial begin
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if (quiet_tail) begin
                @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 60)) @(posedge aclk);
                if (!quiet_tail) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 17)) @(posedge aclk);
                end
            end
        end
    end

    task automatic test_reset_state();
        send_step('0, '0);
    endtask

    task automatic test_pitch_limits();
        send_step(STEP_W'(8191), '0);
        send_step('0, '0);
        send_step(STEP_W'(-8192), '0);
        send_step(STEP_W'(-8192), '0);
        send_step(STEP_W'(1), '0);
        send_step(STEP_W'(-1), '0);
        send_step(STEP_W'(PITCH_LIMIT), '0);
        send_step(STEP_W'(PITCH_LIMIT), '0);
        send_step(STEP_W'(-PITCH_LIMIT), '0);
    endtask

    task automatic test_yaw_wrap();
        // land exactly on each quarter turn, then wrap both ways
        repeat (4) send_step('0, STEP_W'(QUARTER));
        send_step('0, STEP_W'(-1));
        send_step('0, STEP_W'(1));
        send_step('0, STEP_W'(8191));
        send_step('0, STEP_W'(-8192));
        send_step('0, STEP_W'(QUARTER / 2));
    endtask

    task automatic test_combined_extremes();
        send_step(STEP_W'(-1), STEP_W'(-1));
        send_step(STEP_W'(8191), STEP_W'(8191));
        send_step(STEP_W'(-8192), STEP_W'(-8192));
    endtask

    task automatic test_random(input int count);
        int d;
        logic signed [STEP_W-1:0] dp;
        logic signed [STEP_W-1:0] dy;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       dp = STEP_W'($urandom);
                1:       dp = STEP_W'(int'($urandom_range(0, 512)) - 256);
                2:       dp = STEP_W'(int'($urandom_range(0, 4096)) - 2048);
                default: begin
                    // aim at the pitch limit, a few units either side
                    d = ($urandom_range(0, 1) ? PITCH_LIMIT : -PITCH_LIMIT) - pitch_units
                        + int'($urandom_range(0, 6)) - 3;
                    dp = (d >= -8192 && d <= 8191) ? STEP_W'(d) : STEP_W'($urandom);
                end
            endcase
            case ($urandom_range(0, 3))
                0:       dy = STEP_W'($urandom);
                1:       dy = STEP_W'(int'($urandom_range(0, 512)) - 256);
                2:       dy = STEP_W'(int'($urandom_range(0, 4096)) - 2048);
                default: begin
                    // aim at a quarter-turn boundary of yaw
                    d = int'($urandom_range(0, 4)) * QUARTER - yaw_units
                        + int'($urandom_range(0, 4)) - 2;
                    dy = (d >= -8192 && d <= 8191) ? STEP_W'(d) : STEP_W'($urandom);
                end
            endcase
            send_step(dp, dy);
        end
    endtask

    initial begin
        pitch_units = 0;
        yaw_units = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_pitch_limits();
        test_yaw_wrap();
        test_combined_extremes();
        test_random(460);
        hold_until_drained();
        test_random(470);
        quiet_tail = 1'b1;
        test_random(150);

        hold_until_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("covered %0d angle updates and %0d checked vectors, including extreme steps,",
                 items_sent, views_checked);
        $display("%0d pitch clamps, %0d yaw wraps, quarter-turn yaw and limit-exact pitch",
                 clamp_count, wrap_count);
        if (error_count == 0 && view_q.size() == 0) begin
            $display("pitch_yaw_direction_tracker_tb: done, clean");
        end else begin
            $display("pitch_yaw_direction_tracker_tb: done, errors");
        end
        $finish;
    end

endmodule

[pitch_yaw_direction_tracker.f]
+incdir+design
design/pyd_pkg.sv
design/pyd_angle_div.sv
design/pyd_cordic.sv
design/pyd_serial_mul.sv
design/pitch_yaw_direction_tracker.sv
sim/pitch_yaw_direction_tracker_tb.sv
